### src/rti_pkg.sv
package rti_pkg;

  localparam int FIELD_W  = 63;
  localparam int EPS_W    = 16;
  localparam int DIST_W   = 32;
  localparam int BARY_W   = 17;
  localparam int FRAC_OUT = 16;
  localparam int QUO_W    = 33;
  localparam int LANES    = 3;
  localparam int LANE_T   = 0;
  localparam int LANE_U   = 1;
  localparam int LANE_V   = 2;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DET_EPS  = 2'd0,
    REG_DIST_EPS = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_PARALLEL = 3'd1,
    ST_U_OUT    = 3'd2,
    ST_V_OUT    = 3'd3,
    ST_BEHIND   = 3'd4
  } status_t;

  typedef struct packed {
    logic [FIELD_W-1:0] ray_origin;
    logic [FIELD_W-1:0] ray_dir;
    logic [FIELD_W-1:0] vertex_a;
    logic [FIELD_W-1:0] vertex_b;
    logic [FIELD_W-1:0] vertex_c;
  } query_word_t;

  typedef struct packed {
    status_t             status;
    logic [DIST_W-1:0]   hit_dist;
    logic [BARY_W-1:0]   bary_u;
    logic [BARY_W-1:0]   bary_v;
  } result_word_t;

  typedef struct packed {
    status_t status;
    logic    sat;
  } div_side_t;

endpackage

### src/rti_stream_if.sv
interface rti_stream_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/ray_triangle_intersect_top.sv
// Channel   Direction  Word            Contents
// query     sink       query_word_t    ray origin, ray direction, three vertices
// result    source     result_word_t   status, hit distance, barycentric u and v
// cfg       write      index + data    det_epsilon (index 0), dist_epsilon (index 1)
//
// A word is taken every cycle unless the pipeline holds; its result passes through
// five geometry stages, two classification stages, 33 divider stages (one quotient
// bit each) and the output register. The divider depth is what sets the latency.
// Reset is synchronous, clears the valid bits and sets both thresholds to 1.
// When the output register holds a word that is not taken, the whole pipeline
// holds in place and query.ready drops; nothing moves, so nothing is lost.
module ray_triangle_intersect_top
  import rti_pkg::*;
#(
  parameter int COORD_WIDTH = 21,
  parameter int FRAC_BITS   = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  rti_stream_if.sink            query,
  rti_stream_if.source          result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [EPS_W-1:0]      cfg_data
);

  // Width of the determinant and the numerators: edge width plus cross-product
  // width plus two bits of growth for the three-term sum.
  localparam int EW = COORD_WIDTH + 1;
  localparam int XW = 2 * COORD_WIDTH + 3 - FRAC_BITS;
  localparam int DW = EW + XW + 2;

  logic                         en;
  logic [EPS_W-1:0]             det_eps;
  logic [EPS_W-1:0]             dist_eps;

  logic                         geo_valid;
  logic signed [DW-1:0]         det;
  logic signed [DW-1:0]         un;
  logic signed [DW-1:0]         vn;
  logic signed [DW-1:0]         tn;

  logic                         cls_valid;
  logic [DW-2:0]                divisor;
  logic [LANES-1:0][DW-2:0]     dividend;
  div_side_t                    cls_side;

  logic                         div_valid;
  logic [LANES-1:0][QUO_W-1:0]  quotient;
  div_side_t                    div_side;

  logic [DIST_W-1:0]            t_val;
  result_word_t                 word_next;

  // The pipeline moves whenever the output register is free or being drained.
  assign en          = !result.valid || result.ready;
  assign query.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_eps  <= EPS_W'(1);
      dist_eps <= EPS_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DET_EPS:  det_eps  <= cfg_data;
        REG_DIST_EPS: dist_eps <= cfg_data;
        default: ;
      endcase
    end
  end

  rti_geom #(
    .CW (COORD_WIDTH),
    .FB (FRAC_BITS)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (query.valid),
    .in_word   (query.data),
    .out_valid (geo_valid),
    .det       (det),
    .un        (un),
    .vn        (vn),
    .tn        (tn)
  );

  rti_class #(
    .DW (DW)
  ) u_class (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (geo_valid),
    .det       (det),
    .un        (un),
    .vn        (vn),
    .tn        (tn),
    .det_eps   (det_eps),
    .out_valid (cls_valid),
    .divisor   (divisor),
    .dividend  (dividend),
    .side      (cls_side)
  );

  rti_div #(
    .NW (DW - 1)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cls_valid),
    .divisor   (divisor),
    .dividend  (dividend),
    .side_in   (cls_side),
    .out_valid (div_valid),
    .quotient  (quotient),
    .side_out  (div_side)
  );

  // A distance of 65536 or more saturates; a hit closer than dist_eps is
  // reported as behind. Anything but a hit carries zero fields.
  always_comb begin
    t_val = div_side.sat ? '1 : quotient[LANE_T][DIST_W-1:0];
    word_next.status   = div_side.status;
    word_next.hit_dist = '0;
    word_next.bary_u   = '0;
    word_next.bary_v   = '0;
    if (div_side.status == ST_HIT) begin
      if (t_val < DIST_W'(dist_eps)) begin
        word_next.status = ST_BEHIND;
      end else begin
        word_next.hit_dist = t_val;
        word_next.bary_u   = quotient[LANE_U][BARY_W-1:0];
        word_next.bary_v   = quotient[LANE_V][BARY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.data <= word_next;
    end
  end

endmodule

### src/rti_geom.sv
module rti_geom
  import rti_pkg::*;
#(
  parameter int CW = 21,
  parameter int FB = 11,
  localparam int EW  = CW + 1,
  localparam int PRW = 2 * EW,
  localparam int XW  = 2 * CW + 3 - FB,
  localparam int DPW = EW + XW,
  localparam int DW  = DPW + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  query_word_t          in_word,
  output logic                 out_valid,
  output logic signed [DW-1:0] det,
  output logic signed [DW-1:0] un,
  output logic signed [DW-1:0] vn,
  output logic signed [DW-1:0] tn
);

  logic [4:0] vld;

  logic signed [CW-1:0]  org_c [3];
  logic signed [CW-1:0]  dir_c [3];
  logic signed [CW-1:0]  va_c  [3];
  logic signed [CW-1:0]  vb_c  [3];
  logic signed [CW-1:0]  vc_c  [3];

  logic signed [CW-1:0]  dir1 [3];
  logic signed [EW-1:0]  e1_1 [3];
  logic signed [EW-1:0]  e2_1 [3];
  logic signed [EW-1:0]  tv1  [3];

  logic signed [CW-1:0]  dir2 [3];
  logic signed [EW-1:0]  e1_2 [3];
  logic signed [EW-1:0]  e2_2 [3];
  logic signed [EW-1:0]  tv2  [3];
  logic signed [PRW-1:0] pa   [3];
  logic signed [PRW-1:0] pb   [3];
  logic signed [PRW-1:0] qa   [3];
  logic signed [PRW-1:0] qb   [3];

  logic signed [CW-1:0]  dir3 [3];
  logic signed [EW-1:0]  e1_3 [3];
  logic signed [EW-1:0]  e2_3 [3];
  logic signed [EW-1:0]  tv3  [3];
  logic signed [XW-1:0]  pvec [3];
  logic signed [XW-1:0]  qvec [3];

  logic signed [DPW-1:0] dp_det [3];
  logic signed [DPW-1:0] dp_u   [3];
  logic signed [DPW-1:0] dp_v   [3];
  logic signed [DPW-1:0] dp_t   [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_comp
    localparam int A = (k + 1) % 3;
    localparam int B = (k + 2) % 3;

    always_comb begin
      org_c[k] = in_word.ray_origin[k*CW +: CW];
      dir_c[k] = in_word.ray_dir[k*CW +: CW];
      va_c[k]  = in_word.vertex_a[k*CW +: CW];
      vb_c[k]  = in_word.vertex_b[k*CW +: CW];
      vc_c[k]  = in_word.vertex_c[k*CW +: CW];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        // Edges and the origin offset.
        dir1[k] <= dir_c[k];
        e1_1[k] <= EW'(vb_c[k]) - EW'(va_c[k]);
        e2_1[k] <= EW'(vc_c[k]) - EW'(va_c[k]);
        tv1[k]  <= EW'(org_c[k]) - EW'(va_c[k]);

        // Cross product terms: pvec = dir x e2, qvec = tvec x e1.
        dir2[k] <= dir1[k];
        e1_2[k] <= e1_1[k];
        e2_2[k] <= e2_1[k];
        tv2[k]  <= tv1[k];
        pa[k]   <= PRW'(dir1[A]) * PRW'(e2_1[B]);
        pb[k]   <= PRW'(dir1[B]) * PRW'(e2_1[A]);
        qa[k]   <= PRW'(tv1[A]) * PRW'(e1_1[B]);
        qb[k]   <= PRW'(tv1[B]) * PRW'(e1_1[A]);

        // Difference and floor shift back to the coordinate scale.
        dir3[k] <= dir2[k];
        e1_3[k] <= e1_2[k];
        e2_3[k] <= e2_2[k];
        tv3[k]  <= tv2[k];
        pvec[k] <= XW'(((PRW+1)'(pa[k]) - (PRW+1)'(pb[k])) >>> FB);
        qvec[k] <= XW'(((PRW+1)'(qa[k]) - (PRW+1)'(qb[k])) >>> FB);

        // Dot product terms.
        dp_det[k] <= DPW'(e1_3[k]) * DPW'(pvec[k]);
        dp_u[k]   <= DPW'(tv3[k]) * DPW'(pvec[k]);
        dp_v[k]   <= DPW'(dir3[k]) * DPW'(qvec[k]);
        dp_t[k]   <= DPW'(e2_3[k]) * DPW'(qvec[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= DW'(dp_det[0]) + DW'(dp_det[1]) + DW'(dp_det[2]);
      un  <= DW'(dp_u[0]) + DW'(dp_u[1]) + DW'(dp_u[2]);
      vn  <= DW'(dp_v[0]) + DW'(dp_v[1]) + DW'(dp_v[2]);
      tn  <= DW'(dp_t[0]) + DW'(dp_t[1]) + DW'(dp_t[2]);
    end
  end

  assign out_valid = vld[4];

endmodule

### src/rti_class.sv
module rti_class
  import rti_pkg::*;
#(
  parameter int DW = 58
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [DW-1:0]          det,
  input  logic signed [DW-1:0]          un,
  input  logic signed [DW-1:0]          vn,
  input  logic signed [DW-1:0]          tn,
  input  logic [EPS_W-1:0]              det_eps,
  output logic                          out_valid,
  output logic [DW-2:0]                 divisor,
  output logic [LANES-1:0][DW-2:0]      dividend,
  output div_side_t                     side
);

  logic [1:0]           vld;
  logic signed [DW-1:0] a_det;
  logic signed [DW-1:0] a_un;
  logic signed [DW-1:0] a_vn;
  logic signed [DW-1:0] a_tn;
  div_side_t            side_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], in_valid};
    end
  end

  // A negative determinant flips every numerator so the tests below are plain compares.
  always_ff @(posedge clk) begin
    if (en) begin
      if (det < 0) begin
        a_det <= -det;
        a_un  <= -un;
        a_vn  <= -vn;
        a_tn  <= -tn;
      end else begin
        a_det <= det;
        a_un  <= un;
        a_vn  <= vn;
        a_tn  <= tn;
      end
    end
  end

  always_comb begin
    side_next.sat = (DW+FRAC_OUT)'(a_tn) >= ((DW+FRAC_OUT)'(a_det) <<< FRAC_OUT);
    if (a_det == 0 || a_det < $signed(DW'(det_eps))) begin
      side_next.status = ST_PARALLEL;
    end else if (a_un < 0 || a_un > a_det) begin
      side_next.status = ST_U_OUT;
    end else if (a_vn < 0 || ((DW+1)'(a_un) + (DW+1)'(a_vn)) > (DW+1)'(a_det)) begin
      side_next.status = ST_V_OUT;
    end else if (a_tn < 0) begin
      side_next.status = ST_BEHIND;
    end else begin
      side_next.status = ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side             <= side_next;
      divisor          <= a_det[DW-2:0];
      dividend[LANE_T] <= a_tn[DW-2:0];
      dividend[LANE_U] <= a_un[DW-2:0];
      dividend[LANE_V] <= a_vn[DW-2:0];
    end
  end

  assign out_valid = vld[1];

endmodule

### src/rti_div.sv
module rti_div
  import rti_pkg::*;
#(
  parameter int NW = 57
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [NW-1:0]                 divisor,
  input  logic [LANES-1:0][NW-1:0]      dividend,
  input  div_side_t                     side_in,
  output logic                          out_valid,
  output logic [LANES-1:0][QUO_W-1:0]   quotient,
  output div_side_t                     side_out
);

  // One quotient bit per stage for all lanes, restoring division against a shared divisor.
  // Each dividend is scaled by 2^16; its top bits seed the remainder.
  logic [QUO_W-1:0]                vld;
  logic [NW-1:0]                   dsr  [QUO_W];
  logic [LANES-1:0][NW-1:0]        rem  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]     tail [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]     quo  [QUO_W];
  div_side_t                       side [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    logic                        v_prev;
    logic [NW-1:0]               d_prev;
    logic [LANES-1:0][NW-1:0]    r_prev;
    logic [LANES-1:0][QUO_W-1:0] t_prev;
    logic [LANES-1:0][QUO_W-1:0] q_prev;
    div_side_t                   s_prev;
    logic [LANES-1:0][NW-1:0]    r_next;
    logic [LANES-1:0]            take;

    if (s == 0) begin : g_first
      always_comb begin
        v_prev = in_valid;
        d_prev = divisor;
        s_prev = side_in;
        for (int l = 0; l < LANES; l++) begin
          r_prev[l] = dividend[l] >> (QUO_W - FRAC_OUT);
          t_prev[l] = {dividend[l][QUO_W-FRAC_OUT-1:0], {FRAC_OUT{1'b0}}};
          q_prev[l] = '0;
        end
      end
    end else begin : g_rest
      assign v_prev = vld[s-1];
      assign d_prev = dsr[s-1];
      assign s_prev = side[s-1];
      assign r_prev = rem[s-1];
      assign t_prev = tail[s-1];
      assign q_prev = quo[s-1];
    end

    always_comb begin
      logic [NW:0] trial;
      for (int l = 0; l < LANES; l++) begin
        trial     = {r_prev[l], t_prev[l][QUO_W-1]};
        take[l]   = trial >= {1'b0, d_prev};
        r_next[l] = take[l] ? NW'(trial - {1'b0, d_prev}) : NW'(trial);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dsr[s]  <= d_prev;
        side[s] <= s_prev;
        rem[s]  <= r_next;
        for (int l = 0; l < LANES; l++) begin
          tail[s][l] <= {t_prev[l][QUO_W-2:0], 1'b0};
          quo[s][l]  <= {q_prev[l][QUO_W-2:0], take[l]};
        end
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign quotient  = quo[QUO_W-1];
  assign side_out  = side[QUO_W-1];

endmodule

### bench/ray_triangle_intersect_top_tb.sv
`timescale 1ns / 1ps

module ray_triangle_intersect_top_tb;
  import rti_pkg::*;

  localparam int CW = 21;
  localparam int FB = 11;
  // Give the tail of the pipeline some margin beyond the latency of the block.
  localparam int DRAIN_CYCLES = 60;
  localparam longint CYCLE_LIMIT = 600000;
  localparam int RANDOM_PHASES = 5;
  localparam int WORDS_PER_PHASE = 170;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec_t;

  // One row of the directed stimulus. Where known is set, the expected result
  // is typed in by hand; otherwise the intersection predictor supplies it.
  typedef struct {
    query_word_t  q;
    bit           known;
    result_word_t r;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [EPS_W-1:0] cfg_data;

  rti_stream_if #(.word_t(query_word_t)) query_ch ();
  rti_stream_if #(.word_t(result_word_t)) result_ch ();

  ray_triangle_intersect_top uut (
    .clk(clk),
    .rst(rst),
    .query(query_ch),
    .result(result_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Our own copy of the two thresholds, kept in step with every register write.
  logic [EPS_W-1:0] det_eps_shadow;
  logic [EPS_W-1:0] dist_eps_shadow;

  // Results that the block still owes us, oldest first.
  result_word_t pending_hits[$];
  row_t directed_rows[$];

  int errors;
  int results_seen;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and watchdog. The limit is several times the slowest legal run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Intersection predictor
  // ---------------------------------------------------------------------------

  // Pull one signed component out of a packed vector.
  function automatic longint comp(logic [FIELD_W-1:0] w, int k);
    logic signed [CW-1:0] s;
    s = w[k*CW +: CW];
    return longint'(s);
  endfunction

  function automatic vec_t unpack_vec(logic [FIELD_W-1:0] w);
    vec_t v;
    v.x = comp(w, 0);
    v.y = comp(w, 1);
    v.z = comp(w, 2);
    return v;
  endfunction

  function automatic vec_t vec_sub(vec_t a, vec_t b);
    vec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  // Cross product rescaled to FB fraction bits; the arithmetic shift floors.
  function automatic vec_t cross_fx(vec_t a, vec_t b);
    vec_t r;
    r.x = (a.y * b.z - a.z * b.y) >>> FB;
    r.y = (a.z * b.x - a.x * b.z) >>> FB;
    r.z = (a.x * b.y - a.y * b.x) >>> FB;
    return r;
  endfunction

  function automatic longint dot3(vec_t a, vec_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  // Quotient n/d in Q16.16, truncated, saturating once the integer part overflows.
  function automatic logic [DIST_W-1:0] ratio_q16(longint unsigned n, longint unsigned d);
    longint unsigned whole;
    longint unsigned rem;
    longint unsigned frac;
    whole = n / d;
    rem = n % d;
    frac = 0;
    if (whole >= 65536) return '1;
    for (int i = 0; i < FRAC_OUT; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= d) begin
        rem = rem - d;
        frac = frac | 1;
      end
    end
    return DIST_W'((whole << FRAC_OUT) | frac);
  endfunction

  function automatic result_word_t predict_hit(query_word_t q);
    vec_t orig, dir, va, vb, vc, e1, e2, pvec, tvec, qvec;
    longint det, un, vn, tn;
    longint unsigned t;
    result_word_t r;
    orig = unpack_vec(q.ray_origin);
    dir = unpack_vec(q.ray_dir);
    va = unpack_vec(q.vertex_a);
    vb = unpack_vec(q.vertex_b);
    vc = unpack_vec(q.vertex_c);
    e1 = vec_sub(vb, va);
    e2 = vec_sub(vc, va);
    pvec = cross_fx(dir, e2);
    det = dot3(e1, pvec);
    tvec = vec_sub(orig, va);
    qvec = cross_fx(tvec, e1);
    un = dot3(tvec, pvec);
    vn = dot3(dir, qvec);
    tn = dot3(e2, qvec);
    r = '0;
    r.status = ST_HIT;
    // A negative determinant flips every numerator so all tests stay integer compares.
    if (det < 0) begin
      det = -det;
      un = -un;
      vn = -vn;
      tn = -tn;
    end
    if (det == 0 || det < longint'(det_eps_shadow)) begin
      r.status = ST_PARALLEL;
    end else if (un < 0 || un > det) begin
      r.status = ST_U_OUT;
    end else if (vn < 0 || un + vn > det) begin
      r.status = ST_V_OUT;
    end else if (tn < 0) begin
      r.status = ST_BEHIND;
    end else begin
      t = ratio_q16(tn, det);
      if (t < longint'(dist_eps_shadow)) begin
        r.status = ST_BEHIND;
      end else begin
        r.hit_dist = DIST_W'(t);
        r.bary_u = BARY_W'(ratio_q16(un, det));
        r.bary_v = BARY_W'(ratio_q16(vn, det));
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [FIELD_W-1:0] pack_vec(vec_t v);
    logic [CW-1:0] x, y, z;
    x = CW'(v.x);
    y = CW'(v.y);
    z = CW'(v.z);
    return {z, y, x};
  endfunction

  function automatic vec_t mk(longint x, longint y, longint z);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  // Uniform signed value in [-2^sh, 2^sh].
  function automatic longint srand(int sh);
    return longint'($urandom_range(0, 32'(1) << (sh + 1))) - (longint'(1) << sh);
  endfunction

  function automatic vec_t srand_vec(int sh);
    return mk(srand(sh), srand(sh), srand(sh));
  endfunction

  function automatic logic [FIELD_W-1:0] noise_field();
    return FIELD_W'({$urandom, $urandom});
  endfunction

  // Each component picked among the corners of the coordinate range.
  function automatic logic [FIELD_W-1:0] corner_field();
    logic [FIELD_W-1:0] w;
    logic [CW-1:0] corners [4];
    corners[0] = '0;
    corners[1] = '1;
    corners[2] = {1'b0, {(CW-1){1'b1}}};
    corners[3] = {1'b1, {(CW-1){1'b0}}};
    for (int k = 0; k < 3; k++) w[k*CW +: CW] = corners[$urandom_range(0, 3)];
    return w;
  endfunction

  // A ray aimed at a chosen barycentric point of a random triangle, so that
  // most words get past the early rejections and exercise the divider.
  function automatic query_word_t aimed_query();
    query_word_t q;
    vec_t a, e1, e2, p, dir, orig;
    int sh, dsh;
    longint u, v, s;
    sh = $urandom_range(2, 14);
    dsh = $urandom_range(0, 13);
    a = srand_vec(17);
    e1 = srand_vec(sh);
    e2 = srand_vec(sh);
    case ($urandom_range(0, 9))
      0: begin
        u = longint'($urandom_range(0, 320)) - 32;
        v = longint'($urandom_range(0, 256));
      end
      1: begin
        u = longint'($urandom_range(0, 256));
        v = longint'($urandom_range(0, 320)) - 32;
      end
      default: begin
        u = longint'($urandom_range(0, 256));
        v = longint'($urandom_range(0, 32'(256 - u)));
      end
    endcase
    p.x = a.x + ((u * e1.x + v * e2.x) >>> 8);
    p.y = a.y + ((u * e1.y + v * e2.y) >>> 8);
    p.z = a.z + ((u * e1.z + v * e2.z) >>> 8);
    dir = srand_vec(dsh);
    s = longint'($urandom_range(0, 80)) - 12;
    orig.x = p.x - ((dir.x * s) >>> 4);
    orig.y = p.y - ((dir.y * s) >>> 4);
    orig.z = p.z - ((dir.z * s) >>> 4);
    q.ray_origin = pack_vec(orig);
    q.ray_dir = pack_vec(dir);
    q.vertex_a = pack_vec(a);
    q.vertex_b = pack_vec(mk(a.x + e1.x, a.y + e1.y, a.z + e1.z));
    q.vertex_c = pack_vec(mk(a.x + e2.x, a.y + e2.y, a.z + e2.z));
    return q;
  endfunction

  function automatic query_word_t random_query();
    query_word_t q;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      q = aimed_query();
    end else if (pick < 90) begin
      q.ray_origin = noise_field();
      q.ray_dir = noise_field();
      q.vertex_a = noise_field();
      q.vertex_b = noise_field();
      q.vertex_c = noise_field();
    end else begin
      q.ray_origin = corner_field();
      q.ray_dir = corner_field();
      q.vertex_a = corner_field();
      q.vertex_b = corner_field();
      q.vertex_c = corner_field();
    end
    return q;
  endfunction

  function automatic query_word_t scene(vec_t o, vec_t d, vec_t a, vec_t b, vec_t c);
    query_word_t q;
    q.ray_origin = pack_vec(o);
    q.ray_dir = pack_vec(d);
    q.vertex_a = pack_vec(a);
    q.vertex_b = pack_vec(b);
    q.vertex_c = pack_vec(c);
    return q;
  endfunction

  function automatic void add_row(query_word_t q, bit known, status_t st);
    row_t row;
    row.q = q;
    row.known = known;
    row.r = '0;
    row.r.status = st;
    directed_rows.push_back(row);
  endfunction

  // Short gaps are the rule; now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks (called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------------

  task automatic send_query(query_word_t q, bit known, result_word_t typed, bit gaps);
    int gap;
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      query_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    query_ch.valid <= 1'b1;
    query_ch.data <= q;
    @(posedge clk);
    while (!query_ch.ready) @(posedge clk);
    // The word is taken at this edge; the thresholds are stable while words flow.
    pending_hits.push_back(known ? typed : predict_hit(q));
    @(negedge clk);
  endtask

  // Both thresholds are written back to back, only while the pipeline is empty.
  task automatic write_thresholds(logic [EPS_W-1:0] det_eps, logic [EPS_W-1:0] dist_eps);
    cfg_we <= 1'b1;
    cfg_index <= REG_DET_EPS;
    cfg_data <= det_eps;
    @(negedge clk);
    cfg_index <= REG_DIST_EPS;
    cfg_data <= dist_eps;
    @(negedge clk);
    cfg_we <= 1'b0;
    det_eps_shadow = det_eps;
    dist_eps_shadow = dist_eps;
  endtask

  // Pause the sender until every owed result is back, then let the pipeline settle.
  task automatic drain_pipeline();
    query_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------------

  int hold_left;
  bit long_hold_done;

  initial begin
    result_ch.ready = 1'b0;
    hold_left = 0;
    long_hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 250) begin
        // Hold the output long enough for the whole pipeline to back up.
        long_hold_done = 1;
        hold_left = 300;
        result_ch.ready <= 1'b0;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:69]: result_ch.ready <= 1'b1;
          [70:94]: begin
            hold_left = $urandom_range(0, 3);
            result_ch.ready <= 1'b0;
          end
          default: begin
            hold_left = $urandom_range(10, 40);
            result_ch.ready <= 1'b0;
          end
        endcase
      end
    end
  end

  // Compare each word that leaves the block with the oldest expectation.
  initial begin
    result_word_t want;
    result_word_t got;
    errors = 0;
    results_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        results_seen++;
        if (pending_hits.size() == 0) begin
          $error("unexpected result word: status %0d", got.status);
          errors++;
        end else begin
          want = pending_hits.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.hit_dist !== want.hit_dist) begin
            $error("hit_dist: expected %0h, got %0h", want.hit_dist, got.hit_dist);
            errors++;
          end
          if (got.bary_u !== want.bary_u) begin
            $error("bary_u: expected %0h, got %0h", want.bary_u, got.bary_u);
            errors++;
          end
          if (got.bary_v !== want.bary_v) begin
            $error("bary_v: expected %0h, got %0h", want.bary_v, got.bary_v);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    query_word_t q;
    result_word_t none;
    vec_t zero, one_x, one_y, plus_z, minus_z;
    localparam longint ONE = 2048;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_DET_EPS;
    cfg_data = '0;
    query_ch.valid = 1'b0;
    query_ch.data = '0;
    det_eps_shadow = 1;
    dist_eps_shadow = 1;
    none = '0;

    zero = mk(0, 0, 0);
    one_x = mk(ONE, 0, 0);
    one_y = mk(0, ONE, 0);
    plus_z = mk(0, 0, ONE);
    minus_z = mk(0, 0, -ONE);

    // Degenerate triangles are parallel whatever the ray; every other field is zero.
    add_row('0, 1, ST_PARALLEL);
    add_row('1, 1, ST_PARALLEL);
    // Plain hit through the middle of a unit triangle, both windings.
    add_row(scene(mk(ONE / 4, ONE / 4, -ONE), plus_z, zero, one_x, one_y), 0, ST_HIT);
    add_row(scene(mk(ONE / 4, ONE / 4, -ONE), plus_z, zero, one_y, one_x), 0, ST_HIT);
    // Hits exactly on vertices and on the far edge.
    add_row(scene(mk(0, 0, -ONE), plus_z, zero, one_x, one_y), 0, ST_HIT);
    add_row(scene(mk(ONE / 2, ONE / 2, -ONE), plus_z, zero, one_x, one_y), 0, ST_HIT);
    add_row(scene(mk(ONE, 0, -ONE), plus_z, zero, one_x, one_y), 0, ST_HIT);
    // Misses on u, on v and on the sum u + v.
    add_row(scene(mk(-ONE / 4, ONE / 4, -ONE), plus_z, zero, one_x, one_y), 0, ST_U_OUT);
    add_row(scene(mk(ONE / 4, -ONE / 4, -ONE), plus_z, zero, one_x, one_y), 0, ST_V_OUT);
    add_row(scene(mk(3 * ONE / 4, 3 * ONE / 4, -ONE), plus_z, zero, one_x, one_y), 0,
            ST_V_OUT);
    // Triangle behind the origin, and one sitting right at the origin.
    add_row(scene(mk(ONE / 4, ONE / 4, ONE), plus_z, zero, one_x, one_y), 0, ST_BEHIND);
    add_row(scene(mk(ONE / 4, ONE / 4, 0), minus_z, zero, one_x, one_y), 0, ST_BEHIND);
    // Ray lying in the plane of the triangle.
    add_row(scene(mk(ONE / 4, ONE / 4, -ONE), one_x, zero, one_x, one_y), 0, ST_PARALLEL);
    // Tiny direction toward a large, distant triangle; the coordinates wrap to the field width.
    add_row(scene(mk(1, 1, -1000 * ONE), mk(0, 0, 1), zero, mk(512 * ONE, 0, 0),
                  mk(0, 512 * ONE, 0)), 0, ST_HIT);
    // Extremes of the coordinate range in every field.
    q.ray_origin = {3{1'b0, {(CW-1){1'b1}}}};
    q.ray_dir = {3{1'b1, {(CW-1){1'b0}}}};
    q.vertex_a = {3{1'b1, {(CW-1){1'b0}}}};
    q.vertex_b = {3{1'b0, {(CW-1){1'b1}}}};
    q.vertex_c = '1;
    add_row(q, 0, ST_HIT);
    q.ray_origin = {3{1'b1, {(CW-1){1'b0}}}};
    q.ray_dir = {{1'b0, {(CW-1){1'b1}}}, {(2*CW){1'b0}}};
    q.vertex_a = '0;
    q.vertex_b = {{(2*CW){1'b0}}, 1'b0, {(CW-1){1'b1}}};
    q.vertex_c = {{CW{1'b0}}, 1'b1, {(CW-1){1'b0}}, {CW{1'b0}}};
    add_row(q, 0, ST_HIT);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words run with the thresholds as reset left them.
    foreach (directed_rows[i]) begin
      none = directed_rows[i].r;
      send_query(directed_rows[i].q, directed_rows[i].known, none, 1'b0);
    end
    drain_pipeline();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: write_thresholds(16'd1, 16'd1);
        1: write_thresholds(16'd0, 16'd0);
        2: write_thresholds(16'hFFFF, 16'hFFFF);
        default: write_thresholds(EPS_W'($urandom), EPS_W'($urandom_range(0, 4096)));
      endcase
      // With a zero threshold a flat triangle must still come back parallel.
      if (phase == 1) send_query('0, 1, '{status: ST_PARALLEL, default: '0}, 1'b0);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_query(random_query(), 1'b0, none, phase != 0 || n > 60);
      end
      drain_pipeline();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
